/* src/tmcw_pkg.sv */
`default_nettype none

package tmcw_pkg;

  // Screen geometry.
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = ROWS * COLUMNS;

  // Field widths fixed by the item format.
  localparam int FUNC_W   = 2;
  localparam int CHAR_W   = 8;
  localparam int COLOR_W  = 4;
  localparam int CURSOR_W = 11;
  localparam int CELL_W   = 16;

  // Internal widths that follow from the geometry.
  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int SCAN_W = ADDR_W + 1;
  localparam int ROW_W  = $clog2(ROWS);

  localparam logic [ADDR_W-1:0] LAST_CELL      = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] LAST_ROW_START = ADDR_W'((ROWS - 1) * COLUMNS);

  // Reciprocal of COLUMNS for an exact row number of any address.
  localparam int RSHIFT  = ADDR_W + $clog2(COLUMNS);
  localparam int RECIP_W = ADDR_W + 2;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2 ** RSHIFT) / COLUMNS + 1);

  // Cell contents.
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = CHAR_W'(10);
  localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0700;

  // Request function codes.
  localparam logic [FUNC_W-1:0] FUNC_PUT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SET = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_GET = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SET_ROW,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_BLANK,
    ST_FINISH
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CLEAR,
    OP_PUT,
    OP_COPY_RD,
    OP_COPY_WR,
    OP_BLANK
  } ram_op_t;

  typedef struct packed {
    logic    capture;
    logic    step;
    logic    set_row;
    logic    scan_init;
    logic    load_out;
    ram_op_t op;
  } cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              wrap;
    logic              scan_last;
    logic              blank_done;
    logic              out_busy;
  } status_t;

  // Limit a requested index to the last cell of the screen.
  function automatic logic [ADDR_W-1:0] clamp_index(input logic [CURSOR_W-1:0] v);
    logic [ADDR_W-1:0] r;
    if (32'(v) >= CELL_COUNT) r = LAST_CELL;
    else r = ADDR_W'(v);
    return r;
  endfunction

endpackage

`default_nettype wire

/* src/tmcw_in_if.sv */
`default_nettype none

interface tmcw_in_if import tmcw_pkg::*;;
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [CHAR_W-1:0]   char_code;
  logic [COLOR_W-1:0]  fg_color;
  logic [COLOR_W-1:0]  bg_color;
  logic                want_cursor_update;
  logic [CURSOR_W-1:0] cell_index;

  modport source (output valid, func, char_code, fg_color, bg_color,
                  want_cursor_update, cell_index, input ready);
  modport sink   (input valid, func, char_code, fg_color, bg_color,
                  want_cursor_update, cell_index, output ready);
endinterface

`default_nettype wire

/* src/tmcw_out_if.sv */
`default_nettype none

interface tmcw_out_if import tmcw_pkg::*;;
  logic                valid;
  logic                ready;
  logic [CURSOR_W-1:0] cursor_now;
  logic                cursor_update;
  logic [CELL_W-1:0]   cell_value;
  logic                did_scroll;

  modport source (output valid, cursor_now, cursor_update, cell_value, did_scroll,
                  input ready);
  modport sink   (input valid, cursor_now, cursor_update, cell_value, did_scroll,
                  output ready);
endinterface

`default_nettype wire

/* src/tmcw_ram.sv */
`default_nettype none

module tmcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* src/tmcw_ctrl.sv */
`default_nettype none

module tmcw_ctrl import tmcw_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (status.scan_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (status.wrap) state_next = ST_COPY_RD;
        else if (status.func == FUNC_SET) state_next = ST_SET_ROW;
        else state_next = ST_FINISH;
      end
      ST_SET_ROW: state_next = ST_FINISH;
      ST_COPY_RD: state_next = ST_COPY_WR;
      ST_COPY_WR: begin
        if (status.scan_last) state_next = ST_BLANK;
        else state_next = ST_COPY_RD;
      end
      ST_BLANK: begin
        if (status.blank_done) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!status.out_busy) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd      = '0;
    cmd.op   = OP_NONE;
    in_ready = 1'b0;
    case (state)
      ST_CLEAR: cmd.op = OP_CLEAR;
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_EXEC: begin
        cmd.step      = 1'b1;
        cmd.scan_init = status.wrap;
        if (status.func == FUNC_PUT) cmd.op = OP_PUT;
      end
      ST_SET_ROW: cmd.set_row = 1'b1;
      ST_COPY_RD: cmd.op = OP_COPY_RD;
      ST_COPY_WR: cmd.op = OP_COPY_WR;
      ST_BLANK:   cmd.op = OP_BLANK;
      ST_FINISH:  cmd.load_out = !status.out_busy;
      default:    cmd.op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

/* src/tmcw_datapath.sv */
`default_nettype none

module tmcw_datapath import tmcw_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire cmd_t                cmd,
  output status_t                  status,
  input  wire logic [FUNC_W-1:0]   func,
  input  wire logic [CHAR_W-1:0]   char_code,
  input  wire logic [COLOR_W-1:0]  fg_color,
  input  wire logic [COLOR_W-1:0]  bg_color,
  input  wire logic                want_cursor_update,
  input  wire logic [CURSOR_W-1:0] cell_index,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [CURSOR_W-1:0]      cursor_now,
  output logic                     cursor_update,
  output logic [CELL_W-1:0]        cell_value,
  output logic                     did_scroll
);

  localparam logic [SCAN_W-1:0] SCAN_LAST  = SCAN_W'(CELL_COUNT - 1);
  localparam logic [SCAN_W-1:0] BLANK_LAST = SCAN_W'(CELL_COUNT + COLUMNS - 1);
  localparam logic [SCAN_W-1:0] COLS_S     = SCAN_W'(COLUMNS);
  localparam logic [ADDR_W-1:0] COLS_A     = ADDR_W'(COLUMNS);

  // Captured request.
  logic [FUNC_W-1:0]   it_func;
  logic [CHAR_W-1:0]   it_char;
  logic [COLOR_W-1:0]  it_fg;
  logic [COLOR_W-1:0]  it_bg;
  logic                it_want;
  logic [CURSOR_W-1:0] it_idx;

  // Cursor state and scan counter.
  logic [ADDR_W-1:0] cursor;
  logic [ADDR_W-1:0] row_start;
  logic [ROW_W-1:0]  row_q;
  logic [SCAN_W-1:0] scan;

  // Result of the current request, held for the output register.
  logic              res_upd;
  logic [CELL_W-1:0] res_cell;
  logic              res_scroll;

  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_waddr;
  logic [CELL_W-1:0]        ram_wdata;
  logic [ADDR_W-1:0]        ram_raddr;
  logic [CELL_W-1:0]        ram_rdata;
  logic                     newline;
  logic [SCAN_W-1:0]        nxt;
  logic [SCAN_W-1:0]        row_end;
  logic                     wrap;
  logic [ADDR_W-1:0]        idx_clamped;
  logic [ADDR_W+RECIP_W-1:0] recip_prod;

  tmcw_ram #(.WIDTH(CELL_W), .DEPTH(CELL_COUNT)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Cursor step arithmetic.
  always_comb begin
    newline     = (it_char == NEWLINE_CODE);
    row_end     = {1'b0, row_start} + COLS_S;
    nxt         = newline ? row_end : ({1'b0, cursor} + SCAN_W'(1));
    wrap        = (it_func == FUNC_PUT) && (nxt >= SCAN_W'(CELL_COUNT));
    idx_clamped = clamp_index(it_idx);
    recip_prod  = (ADDR_W+RECIP_W)'(idx_clamped) * (ADDR_W+RECIP_W)'(RECIP);
  end

  // Cell memory port selection.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cursor;
    ram_wdata = {it_bg, it_fg, it_char};
    ram_raddr = clamp_index(cell_index);
    case (cmd.op)
      OP_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = scan[ADDR_W-1:0];
        ram_wdata = '0;
      end
      OP_PUT:     ram_we = !newline;
      OP_COPY_RD: ram_raddr = scan[ADDR_W-1:0];
      OP_COPY_WR: begin
        ram_we    = 1'b1;
        ram_waddr = ADDR_W'(scan - COLS_S);
        ram_wdata = ram_rdata;
      end
      OP_BLANK: begin
        ram_we    = 1'b1;
        ram_waddr = ADDR_W'(scan - COLS_S);
        ram_wdata = BLANK_CELL;
      end
      default: ram_we = 1'b0;
    endcase
  end

  // Scan counter for the clearing pass, the row copy and the blank row.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan <= '0;
    end else if (cmd.scan_init) begin
      scan <= COLS_S;
    end else if (cmd.op == OP_CLEAR || cmd.op == OP_COPY_WR || cmd.op == OP_BLANK) begin
      scan <= scan + SCAN_W'(1);
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      it_func <= func;
      it_char <= char_code;
      it_fg   <= fg_color;
      it_bg   <= bg_color;
      it_want <= want_cursor_update;
      it_idx  <= cell_index;
    end
  end

  // Cursor and row start.
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor    <= '0;
      row_start <= '0;
    end else if (cmd.step) begin
      case (it_func)
        FUNC_PUT: begin
          if (wrap) begin
            cursor    <= LAST_ROW_START;
            row_start <= LAST_ROW_START;
          end else begin
            cursor <= nxt[ADDR_W-1:0];
            if (newline || nxt == row_end) row_start <= nxt[ADDR_W-1:0];
          end
        end
        FUNC_SET: cursor <= idx_clamped;
        default: cursor <= cursor;
      endcase
    end else if (cmd.set_row) begin
      row_start <= ADDR_W'(row_q * COLS_A);
    end
  end

  // Row number of a new cursor position and the request result.
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      row_q      <= ROW_W'(recip_prod >> RSHIFT);
      res_upd    <= (it_func == FUNC_PUT) ? it_want : (it_func == FUNC_SET);
      res_cell   <= (it_func == FUNC_GET) ? ram_rdata : '0;
      res_scroll <= wrap;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      cursor_now    <= CURSOR_W'(cursor);
      cursor_update <= res_upd;
      cell_value    <= res_cell;
      did_scroll    <= res_scroll;
    end
  end

  // Status to the controller.
  always_comb begin
    status.func       = it_func;
    status.wrap       = wrap;
    status.scan_last  = (scan == SCAN_LAST);
    status.blank_done = (scan == BLANK_LAST);
    status.out_busy   = out_valid && !out_ready;
  end

endmodule

`default_nettype wire

/* src/text_mode_console_writer.sv */
// Text-mode console writer: an 80x25 buffer of 16-bit cells and a cursor.
// Requests arrive on req (valid/ready); each gives exactly one result on rsp.
// func 0 writes {bg, fg, char} at the cursor and advances it; character 10 is
// a newline that moves the cursor to the start of the next row. Passing the
// last cell scrolls rows up one, blanks the last row to 0x0700 and puts the
// cursor at its start. func 1 sets the cursor (clamped to the last cell) and
// func 2 reads a cell (index clamped the same way).
// One request is worked on at a time. A put, newline or read passes through an
// execute state and a finish state; a set-cursor adds a row-start state between
// them. A scroll copies the cells up one row with a read state and a write state
// per cell and then blanks the last row one cell per cycle, through the cell
// memory with one write port and one registered read port.
// After reset the block clears every cell, one per cycle, with req.ready low;
// the cursor resets to 0.
// The result sits in an output register: a new request is accepted while the
// previous result is still stalled, and the block then waits only when its
// next result is ready and the register is still full.
`default_nettype none

module text_mode_console_writer import tmcw_pkg::*; (
  input wire logic   clk,
  input wire logic   rst,
  tmcw_in_if.sink    req,
  tmcw_out_if.source rsp
);

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  assign req.ready = in_ready;

  tmcw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  tmcw_datapath u_datapath (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .status             (status),
    .func               (req.func),
    .char_code          (req.char_code),
    .fg_color           (req.fg_color),
    .bg_color           (req.bg_color),
    .want_cursor_update (req.want_cursor_update),
    .cell_index         (req.cell_index),
    .out_valid          (rsp.valid),
    .out_ready          (rsp.ready),
    .cursor_now         (rsp.cursor_now),
    .cursor_update      (rsp.cursor_update),
    .cell_value         (rsp.cell_value),
    .did_scroll         (rsp.did_scroll)
  );

endmodule

`default_nettype wire

/* src/tmcw_checker.sv */
`default_nettype none

module tmcw_checker import tmcw_pkg::*; (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                req_ready,
  input wire logic                rsp_valid,
  input wire logic                rsp_ready,
  input wire logic [CURSOR_W-1:0] cursor_now,
  input wire logic                did_scroll
);

  // Reset starts the clearing pass: no request taken, no result shown.
  assert property (@(posedge clk) rst |=> !req_ready && !rsp_valid)
    else $error("request or result active right after reset");

  // A stalled result holds.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(cursor_now) && $stable(did_scroll))
    else $error("stalled result changed");

  // The reported cursor always lies on the screen.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> cursor_now < CURSOR_W'(CELL_COUNT))
    else $error("cursor beyond the last cell");

  // A scroll leaves the cursor at the start of the last row.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && did_scroll |-> cursor_now == CURSOR_W'(LAST_ROW_START))
    else $error("cursor not at last row start after scroll");

endmodule

bind text_mode_console_writer tmcw_checker u_tmcw_checker (
  .clk        (clk),
  .rst        (rst),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .cursor_now (rsp.cursor_now),
  .did_scroll (rsp.did_scroll)
);

`default_nettype wire

/* bench/console_check_pkg.sv */
`timescale 1ns / 100ps

package console_check_pkg;
  import tmcw_pkg::*;

  // The request selector that the block leaves unused.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [CHAR_W-1:0]   char_code;
    logic [COLOR_W-1:0]  fg_color;
    logic [COLOR_W-1:0]  bg_color;
    logic                want_cursor_update;
    logic [CURSOR_W-1:0] cell_index;
  } console_req_t;

  typedef struct packed {
    logic [CURSOR_W-1:0] cursor_now;
    logic                cursor_update;
    logic [CELL_W-1:0]   cell_value;
    logic                did_scroll;
  } console_rsp_t;

  class console_scoreboard;
    logic [CELL_W-1:0] screen [CELL_COUNT];
    int unsigned       cursor_pos;
    console_rsp_t      pending_cursor_reports [$];
    int                mismatches;

    // Reset state: every cell zero and the cursor at the top left.
    function new();
      foreach (screen[i]) screen[i] = '0;
      cursor_pos = 0;
      mismatches = 0;
    endfunction

    // An index past the last cell stands for the last cell.
    function int unsigned limit_index(logic [CURSOR_W-1:0] idx);
      if (int'(idx) >= CELL_COUNT) return CELL_COUNT - 1;
      return int'(idx);
    endfunction

    // Apply one request to the screen copy and return the report it gives.
    function console_rsp_t advance_console(console_req_t r);
      console_rsp_t o;
      o = '0;
      case (r.func)
        FUNC_PUT: begin
          if (r.char_code == NEWLINE_CODE) begin
            cursor_pos = (cursor_pos / COLUMNS + 1) * COLUMNS;
          end else begin
            screen[cursor_pos] = {r.bg_color, r.fg_color, r.char_code};
            cursor_pos++;
          end
          // Past the last cell: move rows up and blank the bottom row.
          if (cursor_pos >= CELL_COUNT) begin
            for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) screen[i] = screen[i + COLUMNS];
            for (int i = (ROWS - 1) * COLUMNS; i < CELL_COUNT; i++) screen[i] = BLANK_CELL;
            cursor_pos = (ROWS - 1) * COLUMNS;
            o.did_scroll = 1'b1;
          end
          o.cursor_update = r.want_cursor_update;
        end
        FUNC_SET: begin
          cursor_pos = limit_index(r.cell_index);
          o.cursor_update = 1'b1;
        end
        FUNC_GET: begin
          o.cell_value = screen[limit_index(r.cell_index)];
        end
        default: begin
        end
      endcase
      o.cursor_now = CURSOR_W'(cursor_pos);
      return o;
    endfunction

    // Called for every accepted request.
    function void note_request(console_req_t r);
      pending_cursor_reports.push_back(advance_console(r));
    endfunction

    task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    // Called for every accepted result; compares it with the oldest prediction.
    task check_result(console_rsp_t got);
      console_rsp_t want;
      if (pending_cursor_reports.size() == 0) begin
        report_mismatch($sformatf("result with nothing outstanding, cursor_now %0d",
                                  got.cursor_now));
        return;
      end
      want = pending_cursor_reports.pop_front();
      if (got.cursor_now !== want.cursor_now)
        report_mismatch($sformatf("cursor_now %0d, predicted %0d",
                                  got.cursor_now, want.cursor_now));
      if (got.cursor_update !== want.cursor_update)
        report_mismatch($sformatf("cursor_update %b, predicted %b",
                                  got.cursor_update, want.cursor_update));
      if (got.cell_value !== want.cell_value)
        report_mismatch($sformatf("cell_value %h, predicted %h",
                                  got.cell_value, want.cell_value));
      if (got.did_scroll !== want.did_scroll)
        report_mismatch($sformatf("did_scroll %b, predicted %b",
                                  got.did_scroll, want.did_scroll));
    endtask
  endclass

endpackage

/* bench/tb_text_mode_console_writer.sv */
`timescale 1ns / 100ps

module tb_text_mode_console_writer;
  import tmcw_pkg::*;
  import console_check_pkg::*;

  localparam int RANDOM_REQUESTS = 1500;
  localparam int CALM_TAIL       = 150;
  localparam int CYCLE_LIMIT     = 30000000;
  localparam int DRAIN_CYCLES    = 20;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic quiet = 1'b0;
  int unsigned sink_hold = 0;
  int unsigned cycle_count = 0;
  int requests_sent = 0;

  console_scoreboard sb;

  tmcw_in_if  req_bus ();
  tmcw_out_if rsp_bus ();

  text_mode_console_writer uut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  // 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Runaway guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side: random stall bursts, none started while quiet.
  always @(negedge clk) begin
    if (rst) begin
      rsp_bus.ready <= 1'b0;
    end else if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
      rsp_bus.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      sink_hold <= $urandom_range(0, 10);
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= 1'b1;
    end
  end

  // Every accepted result is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && rsp_bus.valid && rsp_bus.ready)
      sb.check_result({rsp_bus.cursor_now, rsp_bus.cursor_update,
                       rsp_bus.cell_value, rsp_bus.did_scroll});
  end

  // Present one request from a falling edge until it is accepted; valid stays
  // high afterwards, bar a random gap, so requests can go back to back.
  task automatic send_request(input console_req_t r);
    req_bus.valid              <= 1'b1;
    req_bus.func               <= r.func;
    req_bus.char_code          <= r.char_code;
    req_bus.fg_color           <= r.fg_color;
    req_bus.bg_color           <= r.bg_color;
    req_bus.want_cursor_update <= r.want_cursor_update;
    req_bus.cell_index         <= r.cell_index;
    do @(posedge clk); while (!req_bus.ready);
    sb.note_request(r);
    if (r.func != FUNC_UNUSED) requests_sent++;
    @(negedge clk);
    // Random sender gap after the request.
    if (!quiet && $urandom_range(0, 5) == 0) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
  endtask

  function automatic console_req_t random_fields();
    console_req_t r;
    r.func               = FUNC_W'($urandom_range(0, 3));
    r.char_code          = CHAR_W'($urandom_range(0, 255));
    r.fg_color           = COLOR_W'($urandom_range(0, 15));
    r.bg_color           = COLOR_W'($urandom_range(0, 15));
    r.want_cursor_update = 1'($urandom_range(0, 1));
    r.cell_index         = CURSOR_W'($urandom_range(0, 2047));
    return r;
  endfunction

  task automatic put_char(input int ch, input int fg, input int bg, input bit want);
    console_req_t r;
    r = random_fields();
    r.func = FUNC_PUT;
    r.char_code = CHAR_W'(ch);
    r.fg_color = COLOR_W'(fg);
    r.bg_color = COLOR_W'(bg);
    r.want_cursor_update = want;
    send_request(r);
  endtask

  task automatic set_cursor(input int idx);
    console_req_t r;
    r = random_fields();
    r.func = FUNC_SET;
    r.cell_index = CURSOR_W'(idx);
    send_request(r);
  endtask

  task automatic read_cell(input int idx);
    console_req_t r;
    r = random_fields();
    r.func = FUNC_GET;
    r.cell_index = CURSOR_W'(idx);
    send_request(r);
  endtask

  // One item of typed text: mostly printable characters, some newlines,
  // a few reads, odd bytes and unused selectors.
  task automatic type_item();
    console_req_t r;
    int pick;
    r = random_fields();
    pick = $urandom_range(0, 99);
    if (pick < 68) begin
      r.func = FUNC_PUT;
      r.char_code = CHAR_W'($urandom_range(32, 126));
    end else if (pick < 78) begin
      r.func = FUNC_PUT;
      r.char_code = NEWLINE_CODE;
    end else if (pick < 90) begin
      r.func = FUNC_GET;
      if ($urandom_range(0, 1) == 1)
        r.cell_index = CURSOR_W'((sb.cursor_pos + 2000 - $urandom_range(0, 3)) % 2000);
    end else if (pick < 97) begin
      r.func = FUNC_PUT;
    end else begin
      r.func = FUNC_UNUSED;
    end
    send_request(r);
  endtask

  initial begin
    int kind;
    int run_len;
    console_req_t odd_req;
    sb = new();
    req_bus.valid              = 1'b0;
    req_bus.func               = FUNC_PUT;
    req_bus.char_code          = '0;
    req_bus.fg_color           = '0;
    req_bus.bg_color           = '0;
    req_bus.want_cursor_update = 1'b0;
    req_bus.cell_index         = '0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: cleared buffer, field extremes, newline, clamping, both
    // ways of scrolling, the default colours and the unused selector.
    read_cell(0);
    read_cell(2047);
    put_char(8'hFF, 15, 15, 1'b1);
    put_char(8'h00, 0, 0, 1'b0);
    put_char(NEWLINE_CODE, 15, 15, 1'b1);
    put_char(NEWLINE_CODE, 0, 0, 1'b0);
    read_cell(0);
    read_cell(1);
    put_char("A", 7, 0, 1'b1);
    read_cell(160);
    set_cursor(2047);
    put_char("Z", 9, 6, 1'b1);
    read_cell(1999);
    read_cell(1919);
    set_cursor(1950);
    put_char(NEWLINE_CODE, 3, 12, 1'b0);
    read_cell(1839);
    read_cell(1920);
    set_cursor(2000);
    set_cursor(1999);
    set_cursor(0);
    odd_req = random_fields();
    odd_req.func = FUNC_UNUSED;
    send_request(odd_req);
    put_char(8'h80, 8, 8, 1'b0);
    read_cell(0);
    read_cell(1024);

    // Random: bursts of text, cursor moves, reads and noise.
    while (requests_sent < RANDOM_REQUESTS + 25) begin
      if (requests_sent >= RANDOM_REQUESTS + 25 - CALM_TAIL) quiet = 1'b1;
      else quiet = ($urandom_range(0, 9) == 0);
      kind = $urandom_range(0, 99);
      run_len = $urandom_range(1, 24);
      if (kind < 55) begin
        repeat (run_len) type_item();
      end else if (kind < 68) begin
        set_cursor($urandom_range(0, 2047));
        repeat (run_len) type_item();
      end else if (kind < 78) begin
        // Start near or past the end so that the text scrolls.
        set_cursor($urandom_range(1985, 2047));
        repeat (run_len) type_item();
      end else if (kind < 90) begin
        repeat ($urandom_range(1, 8)) read_cell($urandom_range(0, 2047));
      end else begin
        repeat ($urandom_range(1, 6)) send_request(random_fields());
      end
    end
    quiet = 1'b1;
    req_bus.valid <= 1'b0;

    while (sb.pending_cursor_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/tmcw_pkg.sv
src/tmcw_in_if.sv
src/tmcw_out_if.sv
src/tmcw_ram.sv
src/tmcw_ctrl.sv
src/tmcw_datapath.sv
src/text_mode_console_writer.sv
src/tmcw_checker.sv
bench/console_check_pkg.sv
bench/tb_text_mode_console_writer.sv
